// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks. The checks compile away when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define PLST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PLST_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PLST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLST_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/plst_pkg.sv =====
// ---------------------------------------------------------------------------
// plst_pkg
// Types and constants shared by the positional list store modules.
// ---------------------------------------------------------------------------
package plst_pkg;

  // Field widths of the request and result words.
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  // Default number of list entries.
  localparam int DEF_CAPACITY = 16;

  // Request operations.
  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Request word.
  typedef struct packed {
    logic [1:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        entry_count;
    logic                    empty_res;
  } out_item_t;

endpackage

// ===== src/positional_list_store_core.sv =====
// ---------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of signed 32-bit words with find, search, insert and delete.
// ---------------------------------------------------------------------------
// Each request word is worked on by the sequencer, and the input is not ready
// while it runs. A find reads the one entry at its position, a search reads
// entries from the head until a match, and an insert or delete at position p
// moves every entry from p to the end of the list. The list storage moves one
// entry per cycle through its single read and single write port. The input is
// ready again in the cycle in which the result word appears at the output,
// provided the output register could take it. A new request is taken while the
// previous result still waits in the output register. Storage contents are
// undefined after reset; only positions below the count are ever read, so no
// clearing pass is needed.
`include "assert_macros.svh"

module positional_list_store_core import plst_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic             res_vld;
  logic             res_ready;
  out_item_t        res_data;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // Sequencer and list storage.
  plst_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_vld   (res_vld),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  plst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_vld && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on sequencing and result contents.
  `PLST_NEVER(a_ready_while_result, clk, rst_n, in_ready && res_vld, "ready with result pending")
  `PLST_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready after accept")
  `PLST_ASSERT(a_result_held, clk, rst_n, res_vld && !res_ready |=> res_vld, "result dropped")
  `PLST_ASSERT(a_fail_fields_zero, clk, rst_n, out_valid && (out_data.status != ST_OK) |-> (out_data.read_value == 0) && (out_data.found_position == 0), "failed request carries data")

endmodule

// ===== src/plst_mem.sv =====
// ---------------------------------------------------------------------------
// plst_mem
// Simple dual-port list storage: one write and one registered read a cycle.
// ---------------------------------------------------------------------------
module plst_mem import plst_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/plst_seq.sv =====
// ---------------------------------------------------------------------------
// plst_seq
// Sequencer that walks the list storage one entry a cycle to find, search,
// insert and delete words, and keeps the entry count.
// ---------------------------------------------------------------------------
module plst_seq import plst_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  // Request side
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  // Result side
  output logic             res_vld,
  input  logic             res_ready,
  output out_item_t        res_data,
  // Storage port
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [VAL_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [VAL_W-1:0] mem_rdata
);

  // Count must hold CAPACITY itself; PW leaves headroom for position math.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_INS,
    S_DEL,
    S_DONE
  } state_t;

  state_t           state_r,  state_nxt;
  logic [1:0]       op_r,     op_nxt;
  logic [VAL_W-1:0] val_r,    val_nxt;
  logic [AW-1:0]    base_r,   base_nxt;
  logic [AW-1:0]    idx_r,    idx_nxt;
  logic [AW-1:0]    pidx_r,   pidx_nxt;
  logic [CW-1:0]    rem_r,    rem_nxt;
  logic             pend_r,   pend_nxt;
  logic             first_r,  first_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [VAL_W-1:0] rd_r,     rd_nxt;
  logic [POS_W-1:0] fpos_r,   fpos_nxt;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] p0_ext;
  logic [PW-1:0] rem_ext;
  logic [PW-1:0] last_ext;
  logic [PW-1:0] fpos_ext;
  logic          pos_nonzero;
  logic          pos_in_list;
  logic          pos_in_ins;
  logic          list_full;

  // Position checks against the current count.
  always_comb begin
    pos_ext     = PW'(in_data.position);
    cnt_ext     = PW'(count_r);
    p0_ext      = pos_ext - PW'(1);
    rem_ext     = cnt_ext - p0_ext;
    last_ext    = cnt_ext - PW'(1);
    fpos_ext    = PW'(pidx_r) + PW'(1);
    pos_nonzero = (pos_ext != '0);
    pos_in_list = pos_nonzero && (pos_ext <= cnt_ext);
    pos_in_ins  = pos_nonzero && (pos_ext <= (cnt_ext + PW'(1)));
    list_full   = (count_r == CW'(CAPACITY));
  end

  // Next-state and storage control.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    first_nxt  = first_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    fpos_nxt   = fpos_r;
    in_ready   = 1'b0;
    res_vld    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pidx_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_data.opcode;
          val_nxt    = in_data.value;
          base_nxt   = p0_ext[AW-1:0];
          status_nxt = ST_OK;
          rd_nxt     = '0;
          fpos_nxt   = '0;
          pend_nxt   = 1'b0;
          first_nxt  = 1'b1;
          unique case (in_data.opcode)
            OP_FIND, OP_DELETE: begin
              if (pos_in_list) begin
                idx_nxt   = p0_ext[AW-1:0];
                rem_nxt   = (in_data.opcode == OP_FIND) ? CW'(1) : rem_ext[CW-1:0];
                state_nxt = S_DEL;
              end else begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_DONE;
              end
            end
            OP_SEARCH: begin
              idx_nxt   = '0;
              rem_nxt   = count_r;
              state_nxt = S_SRCH;
            end
            OP_INSERT: begin
              if (list_full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (pos_in_ins) begin
                idx_nxt   = last_ext[AW-1:0];
                rem_nxt   = rem_ext[CW-1:0];
                state_nxt = S_INS;
              end else begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_DONE;
              end
            end
          endcase
        end
      end

      // Read one entry a cycle and compare the word read in the cycle before.
      S_SRCH: begin
        if (pend_r && (mem_rdata == val_r)) begin
          status_nxt = ST_OK;
          fpos_nxt   = fpos_ext[POS_W-1:0];
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
        end else if (rem_r == '0) begin
          status_nxt = ST_NOTFOUND;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + AW'(1);
          rem_nxt  = rem_r - CW'(1);
        end
      end

      // Move words up from the top down, then drop the new word in the gap.
      S_INS: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r - AW'(1);
          rem_nxt  = rem_r - CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we    = 1'b1;
            mem_waddr = base_r;
            mem_wdata = val_r;
            count_nxt = count_r + CW'(1);
            state_nxt = S_DONE;
          end
        end
      end

      // The first word read is the answer; later words move down by one.
      S_DEL: begin
        if (pend_r) begin
          if (first_r) begin
            rd_nxt    = mem_rdata;
            first_nxt = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pidx_r - AW'(1);
            mem_wdata = mem_rdata;
          end
        end
        if (rem_r != '0) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + AW'(1);
          rem_nxt  = rem_r - CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (op_r == OP_DELETE) begin
              count_nxt = count_r - CW'(1);
            end
            state_nxt = S_DONE;
          end
        end
      end

      // Hand the result over once the output register has room.
      S_DONE: begin
        res_vld = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
    end
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    base_r   <= base_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    fpos_r   <= fpos_nxt;
  end

  // Result word; count and empty flag reflect the list after the request.
  always_comb begin
    res_data.status         = status_r;
    res_data.read_value     = rd_r;
    res_data.found_position = fpos_r;
    res_data.entry_count    = cnt_ext[CNT_W-1:0];
    res_data.empty_res      = (count_r == '0);
  end

endmodule
